/* src/crp_pkg.sv */
// package: types and constants of the cache way replacement engine
package crp_pkg;

  localparam int unsigned WAYS = 8;
  localparam int unsigned SETS = 64;
  localparam int unsigned WAY_W = $clog2(WAYS);
  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned ADDR_W = SET_W + WAY_W;
  localparam int unsigned DEPTH = SETS * WAYS;

  localparam logic [63:0] RND_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] RND_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] RND_MUL2 = 64'h94d049bb133111eb;
  localparam logic [63:0] RND_SEED = 64'hdeadbeefcafebabe;

  localparam logic [1:0] CMD_FILL = 2'd0;
  localparam logic [1:0] CMD_HIT = 2'd1;
  localparam logic [1:0] CMD_VICTIM = 2'd2;

  localparam logic [1:0] MODE_LRU = 2'd0;
  localparam logic [1:0] MODE_FIFO = 2'd1;
  localparam logic [1:0] MODE_RANDOM = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_WAYS = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  set_index;
    logic [2:0]  way_index;
    logic [63:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [2:0] victim_way;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CMP,
    S_RINC,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

endpackage

/* src/crp_if.sv */
// interfaces: request and response channels of the replacement engine
interface crp_req_if import crp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crp_rsp_if import crp_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/cache_way_replacement_policy_top.sv */
// top level: cache way replacement engine (lru, fifo, random)
// fill and hit: taken in idle, written to the stamp memories at the transfer edge
// lru/fifo victim: one read and one compare per way in use
// random victim: set by a shared 32x32 multiplier (6 partial products)
// and a bit-serial modulo (64 steps)
// after reset a clearing pass over all 512 entries zeroes the stamps; no request is taken then
module cache_way_replacement_policy_top import crp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_wdata_i,
  crp_req_if.sink    req_i,
  crp_rsp_if.source  rsp_o
);

  logic [63:0] use_mem [DEPTH];
  logic [63:0] fill_mem [DEPTH];

  state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [3:0]  ways_q;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic [WAY_W-1:0]  way_cnt_q, way_cnt_d;
  logic [WAY_W-1:0]  best_way_q, best_way_d;
  logic [63:0] best_q, best_d;
  logic [63:0] rd_use_q, rd_fill_q, rd_sel;
  logic [63:0] rnd_q, rnd_d, rnd_inc;
  logic [63:0] z_q, z_d, acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        pass_q, pass_d;
  logic [5:0]  bit_cnt_q, bit_cnt_d;
  logic [2:0]  rem_q, rem_d;
  logic [3:0]  trial;
  logic [63:0] mconst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [2:0]  vic_q, vic_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic [2:0]  rsp_way_q, rsp_way_d;
  logic [3:0]  n;
  logic        use_we, fill_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [63:0] wr_data;
  logic        req_xfer;

  // effective associativity
  always_comb begin
    if (ways_q == 4'd0) begin
      n = 4'd1;
    end else if (ways_q > 4'(WAYS)) begin
      n = 4'(WAYS);
    end else begin
      n = ways_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LRU;
      ways_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLICY: mode_q <= cfg_wdata_i[1:0];
        CFG_WAYS:   ways_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer = req_i.valid && req_i.ready;

  // stamp memories
  always_comb begin
    use_we = 1'b0;
    fill_we = 1'b0;
    wr_addr = {req_i.data.set_index, req_i.data.way_index};
    wr_data = req_i.data.timestamp;
    if (state_q == S_CLEAR) begin
      use_we = 1'b1;
      fill_we = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (req_xfer) begin
      use_we = (req_i.data.cmd == CMD_FILL) || (req_i.data.cmd == CMD_HIT);
      fill_we = (req_i.data.cmd == CMD_FILL);
    end
  end

  assign rd_addr = {set_q, way_cnt_q};

  always_ff @(posedge clk_i) begin
    if (use_we) begin
      use_mem[wr_addr] <= wr_data;
    end
    if (fill_we) begin
      fill_mem[wr_addr] <= wr_data;
    end
    rd_use_q <= use_mem[rd_addr];
    rd_fill_q <= fill_mem[rd_addr];
  end

  assign rd_sel = (mode_q == MODE_FIFO) ? rd_fill_q : rd_use_q;

  // shared multiplier, 64x64 low half built from three partial products
  assign mconst = pass_q ? RND_MUL2 : RND_MUL1;
  always_comb begin
    unique case (step_q)
      2'd0:    begin mul_a = z_q[31:0];  mul_b = mconst[31:0];  end
      2'd1:    begin mul_a = z_q[31:0];  mul_b = mconst[63:32]; end
      default: begin mul_a = z_q[63:32]; mul_b = mconst[31:0];  end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);
  assign rnd_inc = rnd_q + RND_INC;
  assign trial = {rem_q, z_q[63]};

  always_comb begin
    state_d = state_q;
    clr_cnt_d = clr_cnt_q;
    set_d = set_q;
    way_cnt_d = way_cnt_q;
    best_way_d = best_way_q;
    best_d = best_q;
    rnd_d = rnd_q;
    z_d = z_q;
    acc_d = acc_q;
    step_d = step_q;
    pass_d = pass_q;
    bit_cnt_d = bit_cnt_q;
    rem_d = rem_q;
    vic_d = vic_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_way_d = rsp_way_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_xfer && req_i.data.cmd == CMD_VICTIM) begin
          set_d = req_i.data.set_index;
          way_cnt_d = '0;
          state_d = (mode_q == MODE_RANDOM) ? S_RINC : S_RD;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (way_cnt_q == '0 || rd_sel < best_q) begin
          best_d = rd_sel;
          best_way_d = way_cnt_q;
        end
        if (({1'b0, way_cnt_q} + 4'd1) == n) begin
          vic_d = (way_cnt_q == '0 || rd_sel < best_q) ? way_cnt_q : best_way_q;
          state_d = S_DONE;
        end else begin
          way_cnt_d = way_cnt_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_RINC: begin
        rnd_d = rnd_inc;
        z_d = rnd_inc ^ (rnd_inc >> 30);
        step_d = 2'd0;
        pass_d = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (step_q == 2'd0) begin
          acc_d = prod;
          step_d = 2'd1;
        end else if (step_q == 2'd1) begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          step_d = 2'd2;
        end else begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          step_d = 2'd0;
          if (!pass_q) begin
            z_d = acc_d ^ (acc_d >> 27);
            pass_d = 1'b1;
          end else begin
            z_d = acc_d ^ (acc_d >> 31);
            rem_d = '0;
            bit_cnt_d = 6'd63;
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (trial >= n) begin
          rem_d = 3'(trial - n);
        end else begin
          rem_d = trial[2:0];
        end
        z_d = {z_q[62:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          vic_d = rem_d;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_way_d = vic_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_cnt_q <= '0;
      rnd_q <= RND_SEED;
      rsp_valid_q <= 1'b0;
      step_q <= 2'd0;
      pass_q <= 1'b0;
      way_cnt_q <= '0;
      bit_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rnd_q <= rnd_d;
      rsp_valid_q <= rsp_valid_d;
      step_q <= step_d;
      pass_q <= pass_d;
      way_cnt_q <= way_cnt_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    best_way_q <= best_way_d;
    best_q <= best_d;
    z_q <= z_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    vic_q <= vic_d;
    rsp_way_q <= rsp_way_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data.victim_way = rsp_way_q;

  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside done state");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> ({1'b0, way_cnt_q} < n))
    else $error("scan beyond ways in use");

  a_victim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ({1'b0, rsp_way_q} < n))
    else $error("victim beyond ways in use");

endmodule

/* tb/tb_cache_way_replacement_policy_top.sv */
// testbench: directed and randomized self-checking regression of the cache way replacement engine
module tb_cache_way_replacement_policy_top;
  import crp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_POLICY;
  logic [3:0] cfg_wdata_i = '0;

  crp_req_if req_if ();
  crp_rsp_if rsp_if ();

  cache_way_replacement_policy_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [63:0] use_stamp [SETS*WAYS];
  logic [63:0] fill_stamp [SETS*WAYS];
  logic [63:0] rng_state;
  logic [1:0] mode_q;
  logic [3:0] ways_q;

  req_t pending_reqs[$];
  logic [2:0] expected_victims[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit req_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned victims_seen = 0;
  int unsigned reqs_sent = 0;

  function automatic logic [63:0] mix_next();
    logic [63:0] z;
    rng_state = rng_state + RND_INC;
    z = rng_state;
    z = (z ^ (z >> 30)) * RND_MUL1;
    z = (z ^ (z >> 27)) * RND_MUL2;
    return z ^ (z >> 31);
  endfunction

  function automatic void apply_request(req_t r);
    int unsigned base;
    int unsigned n;
    int unsigned best;
    logic [63:0] low;
    logic [63:0] t;
    base = r.set_index * WAYS;
    if (r.cmd == CMD_FILL || r.cmd == CMD_HIT) begin
      use_stamp[base + r.way_index] = r.timestamp;
      if (r.cmd == CMD_FILL) fill_stamp[base + r.way_index] = r.timestamp;
      return;
    end
    if (r.cmd != CMD_VICTIM) return;
    n = ways_q;
    if (n < 1) n = 1;
    if (n > WAYS) n = WAYS;
    if (mode_q == MODE_RANDOM) begin
      best = mix_next() % n;
    end else begin
      best = 0;
      low = (mode_q == MODE_FIFO) ? fill_stamp[base] : use_stamp[base];
      for (int w = 1; w < n; w++) begin
        t = (mode_q == MODE_FIFO) ? fill_stamp[base + w] : use_stamp[base + w];
        if (t < low) begin
          low = t;
          best = w;
        end
      end
    end
    expected_victims.push_back(best[2:0]);
  endfunction

  // transfer seen at the last rising edge
  always @(posedge clk_i) begin
    req_taken <= rst_ni && req_if.valid && req_if.ready;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.data <= pending_reqs.pop_front();
        req_if.valid <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      apply_request(req_if.data);
      reqs_sent++;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      victims_seen++;
      if (expected_victims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected victim transfer %0d", rsp_if.data.victim_way);
      end else begin
        logic [2:0] exp_way;
        exp_way = expected_victims.pop_front();
        if (rsp_if.data.victim_way !== exp_way) begin
          mismatches++;
          if (mismatches <= 10)
            $display("victim mismatch: expected %0d actual %0d", exp_way,
                     rsp_if.data.victim_way);
        end
      end
    end
  end

  function automatic req_t make_req(logic [1:0] c, logic [5:0] s, logic [2:0] w,
                                    logic [63:0] ts);
    req_t r;
    r.cmd = c;
    r.set_index = s;
    r.way_index = w;
    r.timestamp = ts;
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned k;
    logic [63:0] ts;
    k = $urandom_range(99);
    ts = {$urandom, $urandom};
    if ($urandom_range(3) == 0) ts = ts & 64'hf;
    if (k < 3) return make_req(2'd3, 6'($urandom), 3'($urandom), ts);
    if (k < 40) return make_req(CMD_FILL, 6'($urandom_range(7)), 3'($urandom), ts);
    if (k < 70) return make_req(CMD_HIT, 6'($urandom_range(7)), 3'($urandom), ts);
    return make_req(CMD_VICTIM, 6'($urandom_range(7)), 3'($urandom), ts);
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || req_if.valid || expected_victims.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) mode_q = val[1:0];
    else ways_q = val;
  endtask

  task automatic run_random(int unsigned count);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
    drain();
  endtask

  initial begin
    logic [1:0] modes [4];
    logic [3:0] wset [4];
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < SETS*WAYS; i++) begin
      use_stamp[i] = '0;
      fill_stamp[i] = '0;
    end
    rng_state = RND_SEED;
    mode_q = MODE_LRU;
    ways_q = 4'd8;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset stamps, ties, extremes, every mode and odd settings
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd63, 3'd0, '0));
    pending_reqs.push_back(make_req(CMD_FILL, 6'd0, 3'd7, '1));
    pending_reqs.push_back(make_req(CMD_FILL, 6'd0, 3'd0, 64'd5));
    pending_reqs.push_back(make_req(CMD_HIT, 6'd0, 3'd0, '1));
    pending_reqs.push_back(make_req(2'd3, 6'd0, 3'd1, '0));
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd0, 3'd7, '1));
    for (int w = 0; w < 8; w++)
      pending_reqs.push_back(make_req(CMD_FILL, 6'd63, w[2:0], 64'd100 - w));
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd63, 3'd0, '0));
    drain();
    write_cfg(CFG_POLICY, {2'b0, MODE_FIFO});
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd0, 3'd0, '0));
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd63, 3'd0, '0));
    drain();
    write_cfg(CFG_POLICY, {2'b0, MODE_RANDOM});
    write_cfg(CFG_WAYS, 4'd0);
    for (int i = 0; i < 3; i++) pending_reqs.push_back(make_req(CMD_VICTIM, 6'd1, 3'd0, '0));
    drain();
    write_cfg(CFG_WAYS, 4'd15);
    for (int i = 0; i < 3; i++) pending_reqs.push_back(make_req(CMD_VICTIM, 6'd2, 3'd0, '0));
    drain();
    write_cfg(CFG_POLICY, 4'd3);
    write_cfg(CFG_WAYS, 4'd1);
    pending_reqs.push_back(make_req(CMD_VICTIM, 6'd63, 3'd0, '0));
    drain();

    // backpressure: receiver holds off while sender keeps offering
    write_cfg(CFG_POLICY, {2'b0, MODE_LRU});
    write_cfg(CFG_WAYS, 4'd8);
    recv_hold = 1'b1;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(make_req(CMD_VICTIM, i[5:0], 3'd0, '0));
    repeat (400) @(posedge clk_i);
    recv_hold = 1'b0;
    drain();

    modes = '{MODE_LRU, MODE_FIFO, MODE_RANDOM, 2'd3};
    wset = '{4'd8, 4'd3, 4'd1, 4'd5};
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 85;
      end else if (ph < 8) begin
        send_idle_pct = 85;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(CFG_POLICY, {2'b0, modes[ph % 4]});
      write_cfg(CFG_WAYS, wset[(ph + ph / 4) % 4]);
      run_random(85);
    end

    $display("covered %0d requests and %0d victim choices over lru, fifo, random",
             reqs_sent, victims_seen);
    $display("with ways in use from 0 to 15, stalls on both channels and a long hold-off");
    if (mismatches == 0 && expected_victims.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
